>>> hdl/irpd_pkg.sv
// Shared types and constants for the IRQ resource descriptor parser.
// No dependencies; imported by every module of the block.
package irpd_pkg;

    // Parse phase of the descriptor walk
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY,
        PH_DRAIN
    } irpd_phase_t;

    // Search outcome reported with every result word
    typedef enum logic [1:0] {
        ST_FOUND,
        ST_TERM,
        ST_TRUNC,
        ST_NODATA
    } irpd_status_t;

    // Descriptor type codes
    localparam logic [7:0] TYPE_IRQ     = 8'h04;
    localparam logic [7:0] TYPE_EXT_IRQ = 8'h89;
    localparam logic [7:0] TYPE_END     = 8'h0F;

    // Minimum usable descriptor lengths and body offsets
    localparam int unsigned IRQ_MIN_LEN     = 3;
    localparam int unsigned EXT_MIN_LEN     = 9;
    localparam int unsigned LARGE_HDR_LEN   = 3;
    localparam int unsigned POS_MASK_LO     = 1;
    localparam int unsigned POS_MASK_HI     = 2;
    localparam int unsigned POS_FLAGS       = 3;
    localparam int unsigned POS_COUNT       = 4;
    localparam int unsigned EXT_ENTRY_START = 5;

    // Flag bit positions in the flags byte
    localparam int unsigned IRQ_EDGE_BIT = 0;
    localparam int unsigned IRQ_LOW_BIT  = 3;
    localparam int unsigned EXT_EDGE_BIT = 1;
    localparam int unsigned EXT_LOW_BIT  = 2;

    // Result framing
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned MASK_MAX  = WORD_W * NUM_WORDS;

    // Field widths
    localparam int unsigned LEN_W = 17;
    localparam int unsigned ACC_W = 32;

    // Start of a result run, from parser to emitter
    typedef struct packed {
        logic         valid;
        irpd_status_t status;
        logic         edge_trig;
        logic         act_low;
    } irpd_launch_t;

endpackage

>>> hdl/irq_resource_descriptor_parser_core.sv
// IRQ resource descriptor parser: top level joining walker and result stage.
// Depends on irpd_pkg, irpd_parser and irpd_emitter.
//
// Usage: template bytes enter on the byte channel (data_byte, end_of_buffer,
// byte_valid/byte_ready), one byte per cycle. The walker follows small and
// large descriptors by length and stops at the first usable IRQ or extended
// IRQ descriptor, a terminator, a truncated descriptor or the buffer end.
// Each ended search gives a run of four result words on the result channel
// (result_valid/result_ready): mask quarters 0..3, status and flags repeated,
// last_word set on the fourth.
// Latency: word 0 is valid the cycle after the byte that ends the search;
// the other words follow one per cycle while result_ready is high.
// Throughput: one byte per cycle while byte_ready is high. Bytes after a
// match are still taken while a run is in the result stage, but a byte that
// may end a new search waits until the last word of the run leaves.
// Reset clears the parse state and drops any run in progress.
// When the receiver stalls, the current word holds and input stalls once
// the parser could end another search.
module irq_resource_descriptor_parser_core #(
    parameter int unsigned MASK_BITS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    input  logic        byte_valid,
    output logic        byte_ready,
    output logic [1:0]  status,
    output logic        edge_triggered,
    output logic        active_low,
    output logic [63:0] mask_word,
    output logic [1:0]  word_index,
    output logic        last_word,
    output logic        result_valid,
    input  logic        result_ready
);
    import irpd_pkg::*;

    irpd_launch_t         launch;
    logic                 draining;
    logic                 run_free;
    logic                 accept;
    logic [MASK_BITS-1:0] mask;

    // Input handshake
    assign byte_ready = run_free || draining;
    assign accept     = byte_valid && byte_ready;

    irpd_parser #(
        .MASK_BITS (MASK_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .launch        (launch),
        .draining      (draining),
        .mask          (mask)
    );

    irpd_emitter #(
        .MASK_BITS (MASK_BITS)
    ) u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .launch         (launch),
        .mask           (mask),
        .result_ready   (result_ready),
        .result_valid   (result_valid),
        .run_free       (run_free),
        .status         (status),
        .edge_triggered (edge_triggered),
        .active_low     (active_low),
        .mask_word      (mask_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

endmodule

>>> hdl/irpd_parser.sv
// Byte-serial descriptor walker: parse state, interrupt mask and search outcome.
// Depends on irpd_pkg.
module irpd_parser #(
    parameter int unsigned MASK_BITS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_buffer,
    output irpd_pkg::irpd_launch_t launch,
    output logic                  draining,
    output logic [MASK_BITS-1:0]  mask
);
    import irpd_pkg::*;

    localparam int unsigned MIDX_W = $clog2(MASK_BITS);

    irpd_phase_t         phase_reg, phase_next;
    logic [7:0]          type_reg, type_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [7:0]          count_reg, count_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [MASK_BITS-1:0] mask_reg, mask_next;
    logic [1:0]          flags_reg, flags_next;
    logic                skip_reg, skip_next;

    logic                ended;
    irpd_status_t        status;
    logic [LEN_W-1:0]    idx;
    logic [ACC_W-1:0]    acc_v;

    assign draining = (phase_reg == PH_DRAIN);
    assign mask     = mask_reg;

    // Next state for one accepted byte
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        mask_next  = mask_reg;
        flags_next = flags_reg;
        skip_next  = skip_reg;
        ended      = 1'b0;
        status     = ST_NODATA;
        idx        = pos_reg - LEN_W'(EXT_ENTRY_START);
        acc_v      = '0;
        launch     = '0;

        if (accept && phase_reg != PH_DRAIN)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // new descriptor; the mask only ever holds the current one
                    skip_next  = 1'b0;
                    count_next = '0;
                    acc_next   = '0;
                    flags_next = '0;
                    mask_next  = '0;
                    pos_next   = LEN_W'(1);
                    if (data_byte[7])
                    begin
                        type_next  = data_byte;
                        len_next   = '0;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        type_next  = {4'h0, data_byte[6:3]};
                        len_next   = LEN_W'(data_byte[2:0]) + LEN_W'(1);
                        skip_next  = (type_next == TYPE_IRQ) &&
                                     (len_next < LEN_W'(IRQ_MIN_LEN));
                        phase_next = PH_BODY;
                    end
                end
                PH_LEN_LO:
                begin
                    len_next   = LEN_W'(data_byte);
                    pos_next   = LEN_W'(2);
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = LEN_W'({data_byte, len_reg[7:0]}) + LEN_W'(LARGE_HDR_LEN);
                    pos_next   = LEN_W'(LARGE_HDR_LEN);
                    if (type_reg == TYPE_EXT_IRQ && len_next < LEN_W'(EXT_MIN_LEN))
                    begin
                        skip_next = 1'b1;
                    end
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    pos_next = pos_reg + LEN_W'(1);
                    if (!skip_reg && type_reg == TYPE_IRQ)
                    begin
                        if (pos_reg == LEN_W'(POS_MASK_LO))
                        begin
                            mask_next[7:0] = mask_reg[7:0] | data_byte;
                        end
                        else if (pos_reg == LEN_W'(POS_MASK_HI))
                        begin
                            mask_next[15:8] = mask_reg[15:8] | data_byte;
                        end
                        else if (pos_reg == LEN_W'(POS_FLAGS))
                        begin
                            flags_next = {data_byte[IRQ_LOW_BIT], data_byte[IRQ_EDGE_BIT]};
                        end
                    end
                    else if (!skip_reg && type_reg == TYPE_EXT_IRQ)
                    begin
                        if (pos_reg == LEN_W'(POS_FLAGS))
                        begin
                            flags_next = {data_byte[EXT_LOW_BIT], data_byte[EXT_EDGE_BIT]};
                        end
                        else if (pos_reg == LEN_W'(POS_COUNT))
                        begin
                            count_next = data_byte;
                            // entries must fit inside the descriptor
                            if (LEN_W'(EXT_ENTRY_START) + {7'b0, data_byte, 2'b00} > len_reg)
                            begin
                                skip_next = 1'b1;
                            end
                        end
                        else if (pos_reg >= LEN_W'(EXT_ENTRY_START))
                        begin
                            if (idx[LEN_W-1:2] < (LEN_W-2)'(count_reg))
                            begin
                                acc_v = acc_reg;
                                acc_v[{idx[1:0], 3'b000} +: 8] =
                                    acc_reg[{idx[1:0], 3'b000} +: 8] | data_byte;
                                acc_next = acc_v;
                                if (idx[1:0] == 2'b11)
                                begin
                                    if (acc_v < ACC_W'(MASK_BITS))
                                    begin
                                        mask_next[acc_v[MIDX_W-1:0]] = 1'b1;
                                    end
                                    acc_next = '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // descriptor complete
            if (phase_next == PH_BODY && pos_next >= len_next)
            begin
                if (!skip_next && (type_next == TYPE_IRQ || type_next == TYPE_EXT_IRQ))
                begin
                    ended  = 1'b1;
                    status = ST_FOUND;
                end
                else if (type_next == TYPE_END)
                begin
                    ended  = 1'b1;
                    status = ST_TERM;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end

            // buffer ran out
            if (!ended && end_of_buffer)
            begin
                ended  = 1'b1;
                status = (phase_next == PH_HEADER) ? ST_NODATA : ST_TRUNC;
            end

            if (ended)
            begin
                launch.valid     = 1'b1;
                launch.status    = status;
                launch.edge_trig = (status == ST_FOUND) ? flags_next[0] : 1'b0;
                launch.act_low   = (status == ST_FOUND) ? flags_next[1] : 1'b0;
                phase_next       = PH_DRAIN;
            end
        end

        // end of buffer returns to the header phase; mask is kept for the emitter
        if (accept && end_of_buffer && (ended || phase_reg == PH_DRAIN))
        begin
            phase_next = PH_HEADER;
            type_next  = '0;
            len_next   = '0;
            pos_next   = '0;
            count_next = '0;
            acc_next   = '0;
            flags_next = '0;
            skip_next  = 1'b0;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            type_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            acc_reg   <= '0;
            mask_reg  <= '0;
            flags_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            mask_reg  <= mask_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

>>> hdl/irpd_emitter.sv
// Result stage: sends the four mask words of a finished search.
// Depends on irpd_pkg.
module irpd_emitter #(
    parameter int unsigned MASK_BITS = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  irpd_pkg::irpd_launch_t launch,
    input  logic [MASK_BITS-1:0]   mask,
    input  logic                   result_ready,
    output logic                   result_valid,
    output logic                   run_free,
    output logic [1:0]             status,
    output logic                   edge_triggered,
    output logic                   active_low,
    output logic [63:0]            mask_word,
    output logic [1:0]             word_index,
    output logic                   last_word
);
    import irpd_pkg::*;

    logic                busy_reg, busy_next;
    logic [1:0]          idx_reg, idx_next;
    irpd_status_t        status_reg, status_next;
    logic                edge_reg, edge_next;
    logic                low_reg, low_next;
    logic                fire;
    logic [MASK_MAX-1:0] mask_pad;

    assign fire      = busy_reg && result_ready;
    assign last_word = (idx_reg == 2'(NUM_WORDS - 1));
    assign run_free  = !busy_reg || (fire && last_word);

    // Output word selection
    assign mask_pad       = MASK_MAX'(mask);
    assign result_valid   = busy_reg;
    assign status         = status_reg;
    assign edge_triggered = edge_reg;
    assign active_low     = low_reg;
    assign word_index     = idx_reg;
    assign mask_word      = (status_reg == ST_FOUND) ?
                            mask_pad[{idx_reg, 6'b000000} +: WORD_W] : '0;

    // Run control
    always_comb
    begin
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        edge_next   = edge_reg;
        low_next    = low_reg;
        if (launch.valid)
        begin
            busy_next   = 1'b1;
            idx_next    = '0;
            status_next = launch.status;
            edge_next   = launch.edge_trig;
            low_next    = launch.act_low;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
            if (last_word)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        edge_reg   <= edge_next;
        low_reg    <= low_next;
    end

endmodule

>>> dv/irq_resource_descriptor_parser_core_test.sv
// Testbench for irq_resource_descriptor_parser_core: directed and random resource templates.
// A scoreboard predicts the four-word mask run of every search and checks each result word.
// Depends on irpd_pkg and the core itself.
module irq_resource_descriptor_parser_core_test;
    import irpd_pkg::*;

    localparam int unsigned MASK_BITS    = 256;
    localparam int          RANDOM_ITEMS = 470;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          TAIL_CYCLES  = 8;

    // One expected word of a result run
    typedef struct packed {
        irpd_status_t status;
        logic         edge_trig;
        logic         act_low;
        logic [63:0]  mask;
        logic [1:0]   quarter;
        logic         last_flag;
    } mask_word_t;

    // Shadow of the descriptor walk and the queue of mask words it predicts
    class mask_run_checker;
        irpd_phase_t  phase;
        logic [7:0]   dtype;
        logic [16:0]  dlen;
        logic [16:0]  bpos;
        logic [7:0]   ecount;
        logic [31:0]  eacc;
        logic [63:0]  mask [4];
        logic [1:0]   tflags;
        logic         done;
        logic         dskip;
        mask_word_t   expected_words [$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase  = PH_HEADER;
            dtype  = '0;
            dlen   = '0;
            bpos   = '0;
            ecount = '0;
            eacc   = '0;
            for (int k = 0; k < 4; k++)
                mask[k] = '0;
            tflags = '0;
            done   = 1'b0;
            dskip  = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Queue the four words that close a search
        function void push_run(irpd_status_t st);
            mask_word_t w;
            for (int k = 0; k < 4; k++)
            begin
                w.status    = st;
                w.edge_trig = (st == ST_FOUND) ? tflags[0] : 1'b0;
                w.act_low   = (st == ST_FOUND) ? tflags[1] : 1'b0;
                w.mask      = (st == ST_FOUND) ? mask[k] : 64'd0;
                w.quarter   = 2'(k);
                w.last_flag = (k == 3);
                expected_words.push_back(w);
            end
        endfunction

        // Body byte of the current descriptor
        function void take_body(logic [7:0] b);
            logic [16:0] idx;
            logic [31:0] v;
            if (!dskip && dtype == TYPE_IRQ)
            begin
                if (bpos == 1)
                    mask[0][7:0] = mask[0][7:0] | b;
                else if (bpos == 2)
                    mask[0][15:8] = mask[0][15:8] | b;
                else if (bpos == 3)
                    tflags = {b[3], b[0]};
            end
            else if (!dskip && dtype == TYPE_EXT_IRQ)
            begin
                if (bpos == 3)
                    tflags = {b[2], b[1]};
                else if (bpos == 4)
                begin
                    ecount = b;
                    // entries must fit inside the descriptor
                    if ((5 + 4 * int'(b)) > int'(dlen))
                        dskip = 1'b1;
                end
                else if (bpos >= 5)
                begin
                    idx = bpos - 17'd5;
                    if (idx[16:2] < ecount)
                    begin
                        eacc = eacc | (32'(b) << (8 * idx[1:0]));
                        if (idx[1:0] == 2'd3)
                        begin
                            v = eacc;
                            if (v < MASK_BITS)
                                mask[v[7:6]][v[5:0]] = 1'b1;
                            eacc = '0;
                        end
                    end
                end
            end
            bpos = bpos + 17'd1;
        endfunction

        // Note an accepted byte; returns 0 if the block merely ignores it
        function bit take_byte(logic [7:0] b, logic eob);
            bit           ended;
            irpd_status_t st;
            ended = 1'b0;
            st    = ST_NODATA;
            if (phase == PH_DRAIN || done)
            begin
                if (eob)
                    clear();
                return 1'b0;
            end
            case (phase)
                PH_HEADER:
                begin
                    dskip  = 1'b0;
                    ecount = '0;
                    eacc   = '0;
                    tflags = '0;
                    bpos   = 17'd1;
                    if (b[7])
                    begin
                        dtype = b;
                        dlen  = '0;
                        phase = PH_LEN_LO;
                    end
                    else
                    begin
                        dtype = {4'd0, b[6:3]};
                        dlen  = 17'(b[2:0]) + 17'd1;
                        if (dtype == TYPE_IRQ && dlen < IRQ_MIN_LEN)
                            dskip = 1'b1;
                        phase = PH_BODY;
                    end
                end
                PH_LEN_LO:
                begin
                    dlen  = 17'(b);
                    bpos  = 17'd2;
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    dlen  = 17'(LARGE_HDR_LEN) + 17'({b, dlen[7:0]});
                    bpos  = 17'd3;
                    if (dtype == TYPE_EXT_IRQ && dlen < EXT_MIN_LEN)
                        dskip = 1'b1;
                    phase = PH_BODY;
                end
                default:
                    take_body(b);
            endcase

            // End of a descriptor
            if (phase == PH_BODY && bpos >= dlen)
            begin
                if (!dskip && (dtype == TYPE_IRQ || dtype == TYPE_EXT_IRQ))
                begin
                    ended = 1'b1;
                    st    = ST_FOUND;
                end
                else if (dtype == TYPE_END)
                begin
                    ended = 1'b1;
                    st    = ST_TERM;
                end
                else
                    phase = PH_HEADER;
            end

            // End of buffer without a match
            if (!ended && eob)
            begin
                ended = 1'b1;
                st    = (phase == PH_HEADER) ? ST_NODATA : ST_TRUNC;
            end

            if (ended)
            begin
                push_run(st);
                if (eob)
                    clear();
                else
                begin
                    phase = PH_DRAIN;
                    done  = 1'b1;
                end
            end
            return 1'b1;
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_word(logic [1:0] st, logic et, logic al, logic [63:0] mw,
                                 logic [1:0] wi, logic lw);
            mask_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("result word with none expected: status %0d word_index %0d", st, wi);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (st !== w.status)
            begin
                $error("status: expected %0d, actual %0d", w.status, st);
                errors++;
            end
            if (et !== w.edge_trig)
            begin
                $error("edge_triggered: expected %0d, actual %0d", w.edge_trig, et);
                errors++;
            end
            if (al !== w.act_low)
            begin
                $error("active_low: expected %0d, actual %0d", w.act_low, al);
                errors++;
            end
            if (mw !== w.mask)
            begin
                $error("mask_word: expected %h, actual %h", w.mask, mw);
                errors++;
            end
            if (wi !== w.quarter)
            begin
                $error("word_index: expected %0d, actual %0d", w.quarter, wi);
                errors++;
            end
            if (lw !== w.last_flag)
            begin
                $error("last_word: expected %0d, actual %0d", w.last_flag, lw);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        end_of_buffer;
    logic        byte_valid;
    logic        byte_ready;
    logic [1:0]  status;
    logic        edge_triggered;
    logic        active_low;
    logic [63:0] mask_word;
    logic [1:0]  word_index;
    logic        last_word;
    logic        result_valid;
    logic        result_ready;

    mask_run_checker chk;
    logic [7:0]      tmpl [$];
    int              parsed_count = 0;
    int              sender_idle_pct = 13;
    int              receiver_idle_pct = 65;
    int              quiet_cycles = 0;

    irq_resource_descriptor_parser_core #(
        .MASK_BITS(MASK_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_buffer  (end_of_buffer),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .status         (status),
        .edge_triggered (edge_triggered),
        .active_low     (active_low),
        .mask_word      (mask_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .result_valid   (result_valid),
        .result_ready   (result_ready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, updated on the falling edge
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            chk.check_word(status, edge_triggered, active_low, mask_word, word_index, last_word);
    end

    // Watchdog on cycles with no word accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one byte; called and returns at a falling edge
    task automatic send_byte(logic [7:0] b, logic eob);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid    <= 1'b1;
        data_byte     <= b;
        end_of_buffer <= eob;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        if (chk.take_byte(b, eob))
            parsed_count++;
        @(negedge clk);
    endtask

    // Send the built template, marking its last byte
    task automatic send_template();
        int n;
        n = tmpl.size();
        for (int i = 0; i < n; i++)
            send_byte(tmpl[i], i == n - 1);
        tmpl.delete();
    endtask

    // Hold off the sender until every predicted word has arrived
    task automatic wait_results_drained();
        byte_valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
    endtask

    task automatic add_random_bytes(int n);
        repeat (n)
            tmpl.push_back(8'($urandom));
    endtask

    // Small descriptor of a given type, random body
    task automatic add_small(logic [3:0] t, int len);
        tmpl.push_back({1'b0, t, 3'(len - 1)});
        add_random_bytes(len - 1);
    endtask

    task automatic add_small_other();
        logic [3:0] t;
        t = 4'($urandom_range(0, 15));
        while (t == TYPE_IRQ[3:0] || t == TYPE_END[3:0])
            t = 4'($urandom_range(0, 15));
        add_small(t, $urandom_range(1, 8));
    endtask

    task automatic add_large_other();
        logic [7:0] hdr;
        int         blen;
        hdr = 8'h80 | 8'($urandom_range(0, 127));
        while (hdr == TYPE_EXT_IRQ)
            hdr = 8'h80 | 8'($urandom_range(0, 127));
        blen = $urandom_range(0, 6);
        tmpl.push_back(hdr);
        tmpl.push_back(8'(blen));
        tmpl.push_back(8'h00);
        add_random_bytes(blen);
    endtask

    // Extended IRQ descriptor: form 0 usable, 1 too short, 2 entries overrun
    task automatic add_ext(int form);
        int          cnt;
        int          blen;
        int          pos;
        int          idx;
        int          r;
        logic [31:0] ent [8];
        cnt  = $urandom_range(0, 5);
        blen = 2 + 4 * cnt + $urandom_range(0, 2);
        if (blen < 6)
            blen = 6;
        if (form == 1)
        begin
            cnt  = $urandom_range(0, 3);
            blen = $urandom_range(0, 5);
        end
        else if (form == 2)
        begin
            cnt  = $urandom_range(2, 6);
            blen = 2 + 4 * cnt - $urandom_range(1, 4);
        end
        for (int k = 0; k < 8; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                ent[k] = $urandom_range(0, 255);
            else if (r < 80)
                ent[k] = $urandom_range(255, 256);
            else if (r < 90)
                ent[k] = $urandom_range(256, 1023);
            else
                ent[k] = $urandom;
        end
        tmpl.push_back(TYPE_EXT_IRQ);
        tmpl.push_back(8'(blen));
        tmpl.push_back(8'(blen >> 8));
        for (int i = 0; i < blen; i++)
        begin
            pos = i + 3;
            idx = pos - 5;
            if (pos == 3)
                tmpl.push_back(8'($urandom));
            else if (pos == 4)
                tmpl.push_back(8'(cnt));
            else if (idx / 4 < cnt)
                tmpl.push_back(ent[idx / 4][8 * (idx % 4) +: 8]);
            else
                tmpl.push_back(8'($urandom));
        end
    endtask

    // Large descriptor with a long length, cut short by the buffer end
    task automatic add_long_truncated();
        tmpl.push_back(8'h80 | 8'($urandom_range(0, 127)));
        tmpl.push_back(8'($urandom));
        tmpl.push_back(8'($urandom_range(1, 255)));
        add_random_bytes($urandom_range(0, 4));
    endtask

    // Random template: mostly well-formed, some noise and cut buffers
    task automatic build_random_template();
        int r;
        bit ends_search;
        ends_search = 1'b0;
        if ($urandom_range(0, 99) < 15)
        begin
            add_random_bytes($urandom_range(1, 10));
            return;
        end
        // descriptors passed over before the last one
        repeat ($urandom_range(0, 3))
        begin
            r = $urandom_range(0, 4);
            case (r)
                0: add_small_other();
                1: add_large_other();
                2: add_small(TYPE_IRQ[3:0], $urandom_range(1, 2));
                3: add_ext(1);
                default: add_ext(2);
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            add_small(TYPE_IRQ[3:0], $urandom_range(3, 8));
            ends_search = 1'b1;
        end
        else if (r < 60)
        begin
            add_ext(0);
            ends_search = 1'b1;
        end
        else if (r < 75)
        begin
            add_small(TYPE_END[3:0], $urandom_range(1, 8));
            ends_search = 1'b1;
        end
        else if (r < 85)
            add_long_truncated();
        if (tmpl.size() == 0)
            add_small_other();
        // bytes after the search has ended
        if (ends_search && $urandom_range(0, 99) < 40)
            add_random_bytes($urandom_range(1, 3));
        // cut the buffer somewhere inside
        if (tmpl.size() > 1 && $urandom_range(0, 99) < 12)
        begin
            r = $urandom_range(1, tmpl.size() - 1);
            while (tmpl.size() > r)
                void'(tmpl.pop_back());
        end
    endtask

    // Main stimulus
    initial
    begin
        int base;
        int progress;
        chk           = new();
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        data_byte     = 8'h00;
        end_of_buffer = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // IRQ with full mask, edge and active low
        tmpl = {8'h23, 8'hFF, 8'hFF, 8'h09};
        send_template();
        // short IRQ passed over, then terminator
        tmpl = {8'h21, 8'h5A, 8'h79, 8'h00};
        send_template();
        // extended IRQ: entry 255 sets the top bit, entry 256 sets none
        tmpl = {TYPE_EXT_IRQ, 8'h0A, 8'h00, 8'h06, 8'h02,
                8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_template();
        // buffer ends inside a large header
        tmpl = {TYPE_EXT_IRQ};
        send_template();
        // buffer ends on a descriptor boundary
        tmpl = {8'h08};
        send_template();
        wait_results_drained();

        base = parsed_count;
        while (parsed_count - base < RANDOM_ITEMS)
        begin
            progress = parsed_count - base;
            if (progress < RANDOM_ITEMS / 3)
            begin
                sender_idle_pct   = 13;
                receiver_idle_pct = 65;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct   = 65;
                receiver_idle_pct = 13;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            build_random_template();
            send_template();
            if ($urandom_range(0, 99) < 10)
                wait_results_drained();
        end

        // Drain and finish
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (chk.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
